### sv/brd_pkg.sv
// Shared types, codes and character-class helpers for the block repeat text decoder.
package brd_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 3;
  localparam int unsigned REP_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DATA = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ERR  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FILL = 2'd1,
    PH_HALT = 2'd2,
    PH_EMIT = 2'd3
  } phase_t;

  function automatic logic is_printable(input logic [CHAR_W-1:0] c);
    return (c >= 8'h20) && (c <= 8'h7E);
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= ZERO_CHAR) && (c <= ZERO_CHAR + 8'd9);
  endfunction

endpackage

### sv/brd_if.sv
// Valid/ready channel interfaces for the decoder input and result streams.
interface brd_in_if
  import brd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface brd_out_if
  import brd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   out_char;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  modport source (output valid, output out_char, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_char, input status, input last_of_run,
                  output ready);
endinterface

### sv/block_repeat_text_decoder.sv
// Block repeat text decoder: run-length expansion of repeated text blocks.
// Usage:
//  - in_ch carries one text byte per transfer, or an end-of-stream marker.
//    Plain printable / white-space bytes pass through, one result each.
//  - A digit d (2..limit) opens a block; the next block_length bytes are
//    written into a small block store (synchronous RAM, registered read).
//    After the last of them the block is read back d times onto out_ch.
//  - out_ch carries results; last_of_run marks the final result of an item.
//  - cfg_we/cfg_index/cfg_wdata write block_length and max_repeat; write
//    only while no results are outstanding.
// Timing:
//  - A pass-through result shows on out_ch in the cycle after its transfer;
//    one byte per cycle is sustained while out_ch keeps up.
//  - Expansion streams d*block_length results, one per cycle unless out_ch stalls;
//    the first passes the phase, store read and output registers; the read port
//    sets the pace. in_ch is held off until the last result has left the read stage.
// Reset: block_length 1, max_repeat 9, idle phase; the store is never read unwritten.
// Stall: out_ch back-pressure holds the output register, stops store reads and
//  drops in_ready. After an error or done result the block halts and drains
//  further transfers silently until reset.
module block_repeat_text_decoder
  import brd_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = 7,
  parameter int unsigned DIGIT_LIMIT = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  brd_in_if.sink                in_ch,
  brd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam logic [FILL_W-1:0] MAX_BLK_C = FILL_W'(MAX_BLOCK);
  localparam logic [REP_W-1:0]  DIG_LIM_C = REP_W'(DIGIT_LIMIT);

  // configuration
  logic [FILL_W-1:0] cfg_len_r;
  logic [REP_W-1:0]  cfg_max_rep_r;

  // control state
  phase_t            phase_r, phase_nxt;
  logic [REP_W-1:0]  repeat_count_r, repeat_count_nxt;
  logic [FILL_W-1:0] fill_count_r, fill_count_nxt;

  // expansion sequencer
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic              pend_r, pend_nxt;        // read data waiting in mem_rdata_r
  logic              pend_last_r, pend_last_nxt;

  // block store
  logic [CHAR_W-1:0] store_mem [MAX_BLOCK];
  logic [CHAR_W-1:0] mem_rdata_r;
  logic              mem_we, rd_en;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                last_r, last_nxt;

  // decode
  logic              out_free, move, in_ready, in_fire;
  logic [CHAR_W-1:0] c;
  logic              eos;
  logic [REP_W-1:0]  digit, eff_limit;
  logic [FILL_W-1:0] eff_len, fill_inc;
  logic              digit_ok, fill_ok, block_full;
  logic              last_of_block, last_all;

  assign c   = in_ch.in_byte;
  assign eos = in_ch.end_of_stream;

  assign out_free = !out_valid_r || out_ch.ready;
  assign move     = pend_r && out_free;
  assign in_ready = (phase_r != PH_EMIT) && !pend_r && out_free;
  assign in_fire  = in_ch.valid && in_ready;

  assign eff_len   = (cfg_len_r == '0) ? FILL_W'(1) :
                     ((cfg_len_r > MAX_BLK_C) ? MAX_BLK_C : cfg_len_r);
  assign eff_limit = (cfg_max_rep_r > DIG_LIM_C) ? DIG_LIM_C : cfg_max_rep_r;
  assign digit     = c[REP_W-1:0];
  assign digit_ok  = (digit >= REP_W'(2)) && (digit <= eff_limit);
  assign fill_ok   = !eos && is_printable(c) && !is_digit(c);
  assign fill_inc  = fill_count_r + FILL_W'(1);
  // a block closes once the count reaches the current length
  assign block_full = fill_inc >= eff_len;

  assign last_of_block = (FILL_W'(idx_r) == len_r - FILL_W'(1));
  assign last_all      = last_of_block && (rep_r == REP_W'(1));

  assign rd_en  = (phase_r == PH_EMIT) && (!pend_r || move);
  assign mem_we = in_fire && (phase_r == PH_FILL) && fill_ok && (fill_count_r < MAX_BLK_C);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_fire) begin
          if (eos) begin
            phase_nxt = PH_HALT;
          end else if (is_digit(c)) begin
            phase_nxt = digit_ok ? PH_FILL : PH_HALT;
          end else if (!(is_printable(c) || is_space(c))) begin
            phase_nxt = PH_HALT;
          end
        end
      end
      PH_FILL: begin
        if (in_fire) begin
          if (!fill_ok) begin
            phase_nxt = PH_HALT;
          end else if (block_full) begin
            phase_nxt = PH_EMIT;
          end
        end
      end
      PH_EMIT: begin
        if (rd_en && last_all) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HALT: phase_nxt = PH_HALT;
      default: phase_nxt = PH_HALT;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    repeat_count_nxt = repeat_count_r;
    fill_count_nxt   = fill_count_r;
    idx_nxt          = idx_r;
    rep_nxt          = rep_r;
    len_nxt          = len_r;
    pend_nxt         = pend_r;
    pend_last_nxt    = pend_last_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_char_nxt     = out_char_r;
    status_nxt       = status_r;
    last_nxt         = last_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_fire) begin
          out_char_nxt = '0;
          last_nxt     = 1'b1;
          if (eos) begin
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_DONE;
          end else if (is_digit(c)) begin
            if (digit_ok) begin
              repeat_count_nxt = digit;
              fill_count_nxt   = '0;
            end else begin
              out_valid_nxt = 1'b1;
              status_nxt    = STAT_ERR;
            end
          end else if (is_printable(c) || is_space(c)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = c;
            status_nxt    = STAT_DATA;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_ERR;
          end
        end
      end
      PH_FILL: begin
        if (in_fire) begin
          if (!fill_ok) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = '0;
            status_nxt    = STAT_ERR;
            last_nxt      = 1'b1;
          end else begin
            fill_count_nxt = fill_inc;
            if (block_full) begin
              // latch the run shape for the read-back sequencer
              idx_nxt = '0;
              rep_nxt = repeat_count_r;
              len_nxt = eff_len;
            end
          end
        end
      end
      PH_EMIT: begin
        if (move) begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_char_nxt  = mem_rdata_r;
          status_nxt    = STAT_DATA;
          last_nxt      = pend_last_r;
        end
        if (rd_en) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = last_all;
          if (last_of_block) begin
            idx_nxt = '0;
            rep_nxt = rep_r - REP_W'(1);
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
          if (last_all) begin
            fill_count_nxt   = '0;
            repeat_count_nxt = '0;
          end
        end
      end
      PH_HALT: begin
        // transfers are drained without results
      end
      default: begin
      end
    endcase

    // final read of a run is still waiting after the phase went idle
    if (phase_r != PH_EMIT && move) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_char_nxt  = mem_rdata_r;
      status_nxt    = STAT_DATA;
      last_nxt      = pend_last_r;
    end
  end

  // block store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[fill_count_r[AW-1:0]] <= c;
    end
    if (rd_en) begin
      mem_rdata_r <= store_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r      <= FILL_W'(1);
      cfg_max_rep_r  <= REP_W'(9);
      phase_r        <= PH_IDLE;
      repeat_count_r <= '0;
      fill_count_r   <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_LENGTH: cfg_len_r     <= cfg_wdata[FILL_W-1:0];
          CFG_MAX_REPEAT:   cfg_max_rep_r <= cfg_wdata[REP_W-1:0];
          default: begin
          end
        endcase
      end
      phase_r        <= phase_nxt;
      repeat_count_r <= repeat_count_nxt;
      fill_count_r   <= fill_count_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload and sequencer registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rep_r       <= rep_nxt;
    len_r       <= len_nxt;
    pend_last_r <= pend_last_nxt;
    out_char_r  <= out_char_nxt;
    status_r    <= status_nxt;
    last_r      <= last_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.status      = status_r;
  assign out_ch.last_of_run = last_r;

  // halt is left only through reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("decoder left halt without reset");

  // expansion always has a nonempty run to read
  a_emit_shape: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EMIT |-> (rep_r != '0) && (len_r != '0) && (FILL_W'(idx_r) < len_r))
    else $error("read-back sequencer out of range");

  // a store read never overwrites data still waiting for the output register
  a_no_read_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !out_free |=> pend_r && $stable(mem_rdata_r))
    else $error("pending read data lost");

endmodule
